/* sv/hid_boot_keyboard_key_decoder_assert.svh */
// assertion macros for the key decoder
`ifndef HID_BOOT_KEYBOARD_KEY_DECODER_ASSERT_SVH
`define HID_BOOT_KEYBOARD_KEY_DECODER_ASSERT_SVH

// plain property, checked out of reset
`define HBKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define HBKD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/hbkd_pkg.sv */
`default_nettype none
package hbkd_pkg;

  localparam int KeySlots = 6;
  localparam int MapDepth = 53;

  localparam logic [6:0] MIN_REPORT_LEN = 7'd8;
  localparam logic [7:0] SHIFT_MASK     = 8'h22;
  localparam logic [7:0] FIRST_KEY      = 8'h04;
  localparam logic [7:0] LAST_MAPPED    = 8'h38;
  localparam logic [7:0] USAGE_UP       = 8'h52;
  localparam logic [7:0] USAGE_DOWN     = 8'h51;
  localparam logic [7:0] USAGE_RIGHT    = 8'h4F;
  localparam logic [7:0] USAGE_LEFT     = 8'h50;
  localparam logic [7:0] CHAR_NONE      = 8'd0;
  localparam logic [7:0] CHAR_DEL       = 8'd127;
  localparam logic [7:0] CHAR_UP        = 8'd128;
  localparam logic [7:0] CHAR_DOWN      = 8'd129;
  localparam logic [7:0] CHAR_RIGHT     = 8'd130;
  localparam logic [7:0] CHAR_LEFT      = 8'd131;

  typedef logic [KeySlots-1:0][7:0] key_arr_t;
  typedef logic [KeySlots-1:0]      slot_mask_t;
  typedef logic [2:0]               slot_idx_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } lane_t;

  typedef lane_t [KeySlots-1:0] lane_arr_t;

  localparam logic [7:0] PLAIN_MAP [MapDepth] = '{
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d,
    8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a,
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h0d, 8'h1b, CHAR_DEL, 8'h09, 8'h20, 8'h2d, 8'h3d, 8'h5b, 8'h5d, 8'h5c, 8'h23, 8'h3b,
    8'h27, 8'h60, 8'h2c, 8'h2e, 8'h2f
  };

  localparam logic [7:0] SHIFT_MAP [MapDepth] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d,
    8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a,
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28, 8'h29,
    8'h0d, 8'h1b, CHAR_DEL, 8'h09, 8'h20, 8'h5f, 8'h2b, 8'h7b, 8'h7d, 8'h7c, 8'h7e, 8'h3a,
    8'h22, 8'h7e, 8'h3c, 8'h3e, 8'h3f
  };

  function automatic logic [7:0] translate(input logic [7:0] usage, input logic shift);
    logic [7:0] off;
    logic [5:0] idx;
    logic [7:0] res;
    off = usage - FIRST_KEY;
    idx = off[5:0];
    res = CHAR_NONE;
    if (usage >= FIRST_KEY && usage <= LAST_MAPPED) begin
      res = shift ? SHIFT_MAP[idx] : PLAIN_MAP[idx];
    end else if (usage == USAGE_UP) begin
      res = CHAR_UP;
    end else if (usage == USAGE_DOWN) begin
      res = CHAR_DOWN;
    end else if (usage == USAGE_RIGHT) begin
      res = CHAR_RIGHT;
    end else if (usage == USAGE_LEFT) begin
      res = CHAR_LEFT;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* sv/hbkd_lane.sv */
`default_nettype none
module hbkd_lane (
  input  logic [7:0]        key_i,
  input  hbkd_pkg::key_arr_t prev_i,
  input  logic              shift_i,
  output hbkd_pkg::lane_t   lane_o
);

  logic       seen;
  logic [7:0] ch;

  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < hbkd_pkg::KeySlots; j++) begin
      if (prev_i[j] == key_i) begin
        seen = 1'b1;
      end
    end
  end

  assign ch         = hbkd_pkg::translate(key_i, shift_i);
  assign lane_o.ch  = ch;
  assign lane_o.hit = (key_i >= hbkd_pkg::FIRST_KEY) && !seen && (ch != hbkd_pkg::CHAR_NONE);

endmodule
`default_nettype wire

/* sv/hbkd_merge.sv */
`default_nettype none
`include "hid_boot_keyboard_key_decoder_assert.svh"
module hbkd_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  hbkd_pkg::lane_arr_t  lanes_i,
  output logic                 empty_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 out_last_o
);

  hbkd_pkg::slot_mask_t  mask_q, mask_d, rest;
  logic [hbkd_pkg::KeySlots-1:0][7:0] chars_q;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_char_q, pick_char;
  logic                  out_last_q;
  logic                  out_load, pop;
  hbkd_pkg::slot_idx_t   pick;

  assign out_load = !out_valid_q || out_ready_i;
  assign pop      = out_load && (mask_q != '0);
  assign empty_o  = (mask_q == '0);

  // lowest pending slot goes first
  always_comb begin
    pick = '0;
    for (int i = hbkd_pkg::KeySlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        pick = 3'(i);
      end
    end
  end

  always_comb begin
    rest       = mask_q;
    rest[pick] = 1'b0;
    pick_char  = chars_q[pick];
  end

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      for (int i = 0; i < hbkd_pkg::KeySlots; i++) begin
        mask_d[i] = lanes_i[i].hit;
      end
    end else if (pop) begin
      mask_d = rest;
    end
  end

  assign out_valid_d = out_load ? (mask_q != '0) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < hbkd_pkg::KeySlots; i++) begin
        chars_q[i] <= lanes_i[i].ch;
      end
    end
    if (pop) begin
      out_char_q <= pick_char;
      out_last_q <= (rest == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  `HBKD_ASSERT(a_load_when_drained, !load_i || (mask_q == '0), "report loaded over pending events")
  `HBKD_ASSERT_NEXT(a_pop_shrinks, pop, $countones(mask_q) == $countones($past(mask_q)) - 1, "pop did not retire one event")
  `HBKD_ASSERT_NEXT(a_final_is_last, pop && ($countones(mask_q) == 1), out_valid_q && out_last_q, "final event not marked last")
  `HBKD_ASSERT_NEXT(a_more_not_last, pop && ($countones(mask_q) > 1), !out_last_q, "early event marked last")

endmodule
`default_nettype wire

/* sv/hid_boot_keyboard_key_decoder.sv */
// channel   dir  handshake                          payload
// s_axis    in   s_axis_tvalid_i / s_axis_tready_o  tdata: report length, modifiers, six keys
// m_axis    out  m_axis_tvalid_o / m_axis_tready_i  tdata: key char, tlast: final event
//
// a report is taken when no event of the previous one is still queued
// a report with key events holds the input until they have all left the queue, one with none leaves it ready
// events leave one per cycle while the output is not stalled, from the event queue through the output register
// reset clears the previous-report keys, the queue and the output valid
// a stalled output holds its beat; the queue waits behind it
`default_nettype none
module hid_boot_keyboard_key_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [6:0] report_length, [14:7] modifiers, [22:15] key_0, [30:23] key_1,
  // [38:31] key_2, [46:39] key_3, [54:47] key_4, [62:55] key_5, [63] zero
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] key_char
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  hbkd_pkg::key_arr_t  keys, prev_q;
  hbkd_pkg::lane_arr_t lanes;
  logic [6:0]          report_length;
  logic [7:0]          modifiers;
  logic                shift, accept, load, empty;

  assign report_length = s_axis_tdata_i[6:0];
  assign modifiers     = s_axis_tdata_i[14:7];
  assign shift         = (modifiers & hbkd_pkg::SHIFT_MASK) != 8'h00;

  always_comb begin
    for (int i = 0; i < hbkd_pkg::KeySlots; i++) begin
      keys[i] = s_axis_tdata_i[15 + 8*i +: 8];
    end
  end

  assign s_axis_tready_o = empty;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load            = accept && (report_length >= hbkd_pkg::MIN_REPORT_LEN);

  for (genvar g = 0; g < hbkd_pkg::KeySlots; g++) begin : g_lane
    hbkd_lane u_lane (
      .key_i   (keys[g]),
      .prev_i  (prev_q),
      .shift_i (shift),
      .lane_o  (lanes[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (load) begin
      prev_q <= keys;
    end
  end

  hbkd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .lanes_i     (lanes),
    .empty_o     (empty),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 20;

  typedef struct {
    logic [7:0] key_char;
    logic       last;
  } key_event_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;

  key_event_t          expected_keys[$];
  hbkd_pkg::key_arr_t  held_keys;
  int                  mismatches;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  quiet_cycles;

  hid_boot_keyboard_key_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    held_keys       = '0;
    mismatches      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    quiet_cycles    = 0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // US layout, shifted when either shift key is down
  function automatic logic [7:0] usage_to_char(input logic [7:0] usage, input logic shifted);
    string      lower_row;
    string      upper_row;
    int         idx;
    logic [7:0] ch;
    lower_row = "abcdefghijklmnopqrstuvwxyz1234567890";
    upper_row = "ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()";
    ch = hbkd_pkg::CHAR_NONE;
    if (usage >= hbkd_pkg::FIRST_KEY && usage <= 8'h27) begin
      idx = int'(usage - hbkd_pkg::FIRST_KEY);
      ch = shifted ? upper_row[idx] : lower_row[idx];
    end else begin
      case (usage)
        8'h28:                 ch = 8'd13;
        8'h29:                 ch = 8'd27;
        8'h2a:                 ch = hbkd_pkg::CHAR_DEL;
        8'h2b:                 ch = 8'd9;
        8'h2c:                 ch = " ";
        8'h2d:                 ch = shifted ? "_" : "-";
        8'h2e:                 ch = shifted ? "+" : "=";
        8'h2f:                 ch = shifted ? "{" : "[";
        8'h30:                 ch = shifted ? "}" : "]";
        8'h31:                 ch = shifted ? "|" : 8'h5c;
        8'h32:                 ch = shifted ? "~" : "#";
        8'h33:                 ch = shifted ? ":" : ";";
        8'h34:                 ch = shifted ? "\"" : "'";
        8'h35:                 ch = shifted ? "~" : 8'h60;
        8'h36:                 ch = shifted ? "<" : ",";
        8'h37:                 ch = shifted ? ">" : ".";
        8'h38:                 ch = shifted ? "?" : "/";
        hbkd_pkg::USAGE_UP:    ch = hbkd_pkg::CHAR_UP;
        hbkd_pkg::USAGE_DOWN:  ch = hbkd_pkg::CHAR_DOWN;
        hbkd_pkg::USAGE_RIGHT: ch = hbkd_pkg::CHAR_RIGHT;
        hbkd_pkg::USAGE_LEFT:  ch = hbkd_pkg::CHAR_LEFT;
        default:               ch = hbkd_pkg::CHAR_NONE;
      endcase
    end
    return ch;
  endfunction

  function automatic void predict_key_events(input logic [6:0] len, input logic [7:0] mods,
                                             input hbkd_pkg::key_arr_t keys);
    key_event_t fresh[$];
    key_event_t ev;
    logic       shifted;
    logic       held;
    logic [7:0] ch;
    if (len < hbkd_pkg::MIN_REPORT_LEN) return;
    shifted = (mods & hbkd_pkg::SHIFT_MASK) != 8'h00;
    for (int s = 0; s < hbkd_pkg::KeySlots; s++) begin
      if (keys[s] < hbkd_pkg::FIRST_KEY) continue;
      held = 1'b0;
      for (int p = 0; p < hbkd_pkg::KeySlots; p++) begin
        if (held_keys[p] == keys[s]) held = 1'b1;
      end
      if (held) continue;
      ch = usage_to_char(keys[s], shifted);
      if (ch != hbkd_pkg::CHAR_NONE) begin
        ev.key_char = ch;
        ev.last     = 1'b0;
        fresh.push_back(ev);
      end
    end
    held_keys = keys;
    if (fresh.size() != 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[i]) expected_keys.push_back(fresh[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // one report beat, with a random idle gap in front
  task automatic send_report(input logic [6:0] len, input logic [7:0] mods,
                             input hbkd_pkg::key_arr_t keys);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, keys, mods, len};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_key_events(len, mods, keys);
    @(negedge clk_i);
  endtask

  task automatic wait_for_events_drained();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_keys.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_key_events
    key_event_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_keys.size() == 0) begin
        report_mismatch("unexpected key event", hbkd_pkg::CHAR_NONE, m_axis_tdata_o);
      end else begin
        want = expected_keys.pop_front();
        if (m_axis_tdata_o !== want.key_char)
          report_mismatch("key_char", want.key_char, m_axis_tdata_o);
        if (m_axis_tlast_o !== want.last)
          report_mismatch("tlast", {7'd0, want.last}, {7'd0, m_axis_tlast_o});
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // every mapped usage and the up arrow, both shift states, both shift bits
  task automatic test_key_mapping();
    hbkd_pkg::key_arr_t keys;
    logic [7:0]         usage;
    logic               shifted;
    logic [7:0]         mods;
    for (int pass = 0; pass < 2; pass++) begin
      for (int g = 0; g < 9; g++) begin
        for (int s = 0; s < hbkd_pkg::KeySlots; s++) begin
          usage = hbkd_pkg::FIRST_KEY + 8'(g * hbkd_pkg::KeySlots + s);
          keys[s] = (usage > hbkd_pkg::LAST_MAPPED) ? hbkd_pkg::USAGE_UP : usage;
        end
        shifted = ((g + pass) % 2) == 1;
        if (shifted) mods = (g % 4 < 2) ? 8'h02 : ((g == 7) ? 8'hff : 8'h20);
        else mods = (g % 4 < 2) ? 8'h00 : 8'hdd;
        send_report(7'(8 + g * 7), mods, keys);
      end
    end
  endtask

  // short reports must leave the held keys alone
  task automatic test_short_reports();
    send_report(7'd0, 8'h00, {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04});
    send_report(7'd7, 8'hff, {8'hff, 8'h80, 8'h51, 8'h50, 8'h4f, 8'h04});
    send_report(7'd8, 8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h38});
  endtask

  task automatic test_special_cases();
    // codes below four are skipped
    send_report(7'd8, 8'h00, {8'h00, 8'h05, 8'h03, 8'h02, 8'h01, 8'h00});
    // one held key, one new
    send_report(7'd9, 8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h05});
    // repeated new codes give one event per slot
    send_report(7'd8, 8'h22, {8'h00, 8'h52, 8'h52, 8'h07, 8'h07, 8'h07});
    // unmapped usages give nothing
    send_report(7'd64, 8'h00, {8'h00, 8'h80, 8'hff, 8'h53, 8'h4e, 8'h39});
    send_report(7'd8, 8'h00, '0);
    // both tilde sources, then the remaining arrows
    send_report(7'd8, 8'h22, {8'h00, 8'h00, 8'h00, 8'h00, 8'h35, 8'h32});
    send_report(7'd8, 8'h00, {8'h00, 8'h00, 8'h50, 8'h4f, 8'h51, 8'h2a});
  endtask

  function automatic logic [7:0] pick_usage();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'($urandom_range(3));
    if (r < 45) return held_keys[$urandom_range(hbkd_pkg::KeySlots-1)];
    if (r < 80) begin
      return 8'($urandom_range(int'(hbkd_pkg::LAST_MAPPED), int'(hbkd_pkg::FIRST_KEY)));
    end
    if (r < 88) begin
      return 8'($urandom_range(int'(hbkd_pkg::USAGE_UP), int'(hbkd_pkg::USAGE_RIGHT)));
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic test_random_reports(input int n_full);
    hbkd_pkg::key_arr_t keys;
    logic [6:0]         len;
    int                 sent;
    sent = 0;
    while (sent < n_full) begin
      for (int s = 0; s < hbkd_pkg::KeySlots; s++) keys[s] = pick_usage();
      if ($urandom_range(9) == 0) keys[$urandom_range(hbkd_pkg::KeySlots-1)] = keys[0];
      if ($urandom_range(9) == 0) len = 7'($urandom_range(7));
      else len = 7'($urandom_range(64, 8));
      send_report(len, 8'($urandom_range(255)), keys);
      if (len >= hbkd_pkg::MIN_REPORT_LEN) sent++;
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct  = 30;
    recv_stall_pct = 30;
    test_key_mapping();
    test_short_reports();
    test_special_cases();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_reports(28);
    wait_for_events_drained();
    send_idle_pct  = 54;
    recv_stall_pct = 0;
    test_random_reports(28);
    send_idle_pct  = 0;
    recv_stall_pct = 54;
    test_random_reports(28);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    test_random_reports(28);

    wait_for_events_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && expected_keys.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
